[rtl/core/bma_pkg.sv]
`default_nettype none
package bma_pkg;
  localparam int MemUnits = 1024;
  localparam int LvlW = 4;
  localparam int NodeW = 11;
  localparam int NodeDepth = 2048;

  localparam logic [1:0] NODE_ABSENT = 2'd0;
  localparam logic [1:0] NODE_FREE = 2'd1;
  localparam logic [1:0] NODE_USED = 2'd2;
  localparam logic [1:0] NODE_SPLIT = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [10:0] request_size;
    logic [9:0]  free_address;
  } bma_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  block_start;
    logic [10:0] block_size;
  } bma_out_t;
endpackage
`default_nettype wire

[rtl/core/bma_ram.sv]
`default_nettype none
module bma_ram #(
  parameter int Width = 2,
  parameter int Depth = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/buddy_memory_allocator_unit.sv]
// Buddy allocator over 1024 units, kept as a heap-ordered tree of 2-bit node
// states in one RAM with a registered read port.
// Request channel: present a request with start high while busy is low; it is
// taken at that edge. mode 0 allocates request_size units (0 counts as 1),
// mode 1 frees the block whose start unit is free_address.
// Result channel: out_valid is high for exactly one cycle with the result;
// the receiver cannot stall, so the result must be taken then.
// An allocate scans every node once, one RAM read per cycle, then splits
// the chosen block, each split through S_SPLIT_A, S_SPLIT_B and S_SPLIT_C (up to 10 splits).
// A free walks down at most 10 levels through S_FD_RD and S_FD_CHK and merges up
// at most 10 levels through S_FM_RD, S_FM_CHK and S_FM_PAR. One request is handled
// at a time; busy stays high until the result is shown.
// After reset a clearing pass writes every node of the RAM and sets the root free;
// busy is high meanwhile.
`default_nettype none
module buddy_memory_allocator_unit
  import bma_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire bma_in_t  in_req,
  output logic          out_valid,
  output bma_out_t      out_res
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_SPLIT_A, S_SPLIT_B, S_SPLIT_C, S_MARK,
    S_FD_RD, S_FD_CHK, S_FM_RD, S_FM_CHK, S_FM_PAR, S_DONE
  } state_t;

  state_t state_r;
  logic [NodeW-1:0] node_r, scan_r;
  logic [LvlW-1:0] scan_lvl_r;
  logic [NodeW-1:0] best_r;
  logic [10:0] bsize_r, req_r, sz_r;
  logic [9:0] st_r, addr_r;
  logic [NodeW-1:0] lvl_first_r;
  logic scan_valid_r;
  logic found_r;
  logic we;
  logic [NodeW-1:0] waddr, raddr;
  logic [1:0] wdata, rdata;
  logic [11:0] scan_sz;

  bma_ram #(.Width(2), .Depth(NodeDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state_r != S_IDLE);
  assign raddr = (state_r == S_FM_RD) ? (node_r ^ NodeW'(1)) : node_r;
  assign scan_sz = 12'(MemUnits) >> scan_lvl_r;

  always_comb begin
    we = 1'b0;
    waddr = node_r;
    wdata = NODE_ABSENT;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wdata = (node_r == NodeW'(1)) ? NODE_FREE : NODE_ABSENT;
      end
      S_SPLIT_A: begin we = 1'b1; wdata = NODE_SPLIT; end
      S_SPLIT_B: begin we = 1'b1; waddr = {node_r[NodeW-2:0], 1'b0}; wdata = NODE_FREE; end
      S_SPLIT_C: begin we = 1'b1; waddr = {node_r[NodeW-2:0], 1'b1}; wdata = NODE_FREE; end
      S_MARK: begin we = 1'b1; wdata = NODE_USED; end
      S_FM_RD: begin we = 1'b1; wdata = NODE_FREE; end
      S_FM_CHK: begin
        we = (rdata == NODE_FREE) && (node_r != NodeW'(1));
        wdata = NODE_ABSENT;
      end
      S_FM_PAR: begin we = 1'b1; waddr = node_r ^ NodeW'(1); wdata = NODE_ABSENT; end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      node_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          node_r <= node_r + NodeW'(1);
          if (node_r == NodeW'(NodeDepth - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_r <= (in_req.request_size == 11'd0) ? 11'd1 : in_req.request_size;
            addr_r <= in_req.free_address;
            node_r <= NodeW'(1);
            found_r <= 1'b0;
            sz_r <= 11'(MemUnits);
            st_r <= '0;
            if (!in_req.mode) begin
              scan_valid_r <= 1'b0;
              state_r <= S_SCAN;
            end else begin
              state_r <= S_FD_RD;
            end
          end
        end
        S_SCAN: begin
          // The read of node_r returns next cycle; judge the previous node.
          if (scan_valid_r && rdata == NODE_FREE && {1'b0, req_r} <= scan_sz &&
              (!found_r || scan_sz < {1'b0, bsize_r})) begin
            found_r <= 1'b1;
            best_r <= scan_r;
            bsize_r <= scan_sz[10:0];
            st_r <= 10'((scan_r - lvl_first_r) << (4'd10 - scan_lvl_r));
          end
          scan_r <= node_r;
          scan_valid_r <= (node_r != '0);
          if (node_r == NodeW'(1)) begin
            scan_lvl_r <= '0; lvl_first_r <= NodeW'(1);
          end else if ((node_r & (node_r - NodeW'(1))) == '0) begin
            scan_lvl_r <= scan_lvl_r + LvlW'(1); lvl_first_r <= node_r;
          end
          if (scan_valid_r && scan_r == NodeW'(NodeDepth - 1)) begin
            state_r <= S_MARK;
          end
          node_r <= node_r + NodeW'(1);
          if (scan_valid_r && scan_r == NodeW'(NodeDepth - 1)) begin
            node_r <= best_r;
            if (!(rdata == NODE_FREE && {1'b0, req_r} <= scan_sz &&
                  (!found_r || scan_sz < {1'b0, bsize_r}))) begin
              if (!found_r) begin
                out_res <= '{STATUS_NO_SPACE, 10'd0, 11'd0};
                state_r <= S_DONE;
              end else if ((bsize_r >> 1) >= req_r && bsize_r != 11'd1) begin
                state_r <= S_SPLIT_A;
              end
            end else begin
              node_r <= scan_r;
              bsize_r <= scan_sz[10:0];
              if ((scan_sz[10:0] >> 1) >= req_r && scan_sz[10:0] != 11'd1)
                state_r <= S_SPLIT_A;
            end
          end
        end
        S_SPLIT_A: state_r <= S_SPLIT_B;
        S_SPLIT_B: state_r <= S_SPLIT_C;
        S_SPLIT_C: begin
          node_r <= {node_r[NodeW-2:0], 1'b0};
          bsize_r <= bsize_r >> 1;
          state_r <= ((bsize_r >> 2) >= req_r && bsize_r > 11'd2) ? S_SPLIT_A : S_MARK;
        end
        S_MARK: begin
          out_res <= '{STATUS_OK, st_r, bsize_r};
          state_r <= S_DONE;
        end
        S_FD_RD: state_r <= S_FD_CHK;
        S_FD_CHK: begin
          if (rdata == NODE_SPLIT && sz_r > 11'd1) begin
            if (addr_r >= st_r + 10'(sz_r >> 1)) begin
              node_r <= {node_r[NodeW-2:0], 1'b1};
              st_r <= st_r + 10'(sz_r >> 1);
            end else begin
              node_r <= {node_r[NodeW-2:0], 1'b0};
            end
            sz_r <= sz_r >> 1;
            state_r <= S_FD_RD;
          end else if (rdata != NODE_USED || st_r != addr_r) begin
            out_res <= '{STATUS_BAD_FREE, 10'd0, 11'd0};
            state_r <= S_DONE;
          end else begin
            out_res <= '{STATUS_OK, st_r, sz_r};
            state_r <= S_FM_RD;
          end
        end
        S_FM_RD: state_r <= S_FM_CHK;
        S_FM_CHK: begin
          if (rdata == NODE_FREE && node_r != NodeW'(1)) begin
            state_r <= S_FM_PAR;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_FM_PAR: begin
          node_r <= node_r >> 1;
          state_r <= S_FM_RD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
module tb
  import bma_pkg::*;
;

  localparam int TreeNodes = 2 * MemUnits;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  bma_in_t in_req;
  logic out_valid;
  bma_out_t out_res;

  buddy_memory_allocator_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res)
  );

  // Shadow copy of the buddy tree, heap order, node 1 is the root.
  logic [1:0] tree [TreeNodes];
  bma_out_t pending_results[$];
  // Starts of blocks currently held, used to build legal free requests.
  int held_starts[$];
  int fail_count = 0;
  int result_count = 0;
  int alloc_count = 0;
  int free_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void reset_tree();
    for (int i = 0; i < TreeNodes; i++) tree[i] = NODE_ABSENT;
    tree[1] = NODE_FREE;
  endfunction

  function automatic bma_out_t predict_allocate(int req);
    bma_out_t r;
    int lvl_first;
    int sz;
    int best;
    int bsize;
    int bstart;
    lvl_first = 1;
    sz = MemUnits;
    best = 0;
    bsize = 0;
    bstart = 0;
    r = '0;
    if (req == 0) req = 1;
    for (int i = 1; i < TreeNodes; i++) begin
      if (i >= 2 * lvl_first) begin
        lvl_first *= 2;
        sz /= 2;
      end
      if (tree[i] == NODE_FREE && sz >= req && (best == 0 || sz < bsize)) begin
        best = i;
        bsize = sz;
        bstart = (i - lvl_first) * sz;
      end
    end
    if (best == 0) begin
      r.status = STATUS_NO_SPACE;
      return r;
    end
    while (bsize / 2 >= req && 2 * best + 1 < TreeNodes) begin
      tree[best] = NODE_SPLIT;
      tree[2 * best] = NODE_FREE;
      tree[2 * best + 1] = NODE_FREE;
      best = 2 * best;
      bsize /= 2;
    end
    tree[best] = NODE_USED;
    r.status = STATUS_OK;
    r.block_start = bstart[9:0];
    r.block_size = bsize[10:0];
    held_starts.push_back(bstart);
    return r;
  endfunction

  function automatic bma_out_t predict_free(int addr);
    bma_out_t r;
    int n;
    int sz;
    int st;
    n = 1;
    sz = MemUnits;
    st = 0;
    r = '0;
    r.status = STATUS_BAD_FREE;
    while (tree[n] == NODE_SPLIT && sz > 1 && 2 * n + 1 < TreeNodes) begin
      sz /= 2;
      if (addr >= st + sz) begin
        n = 2 * n + 1;
        st += sz;
      end else begin
        n = 2 * n;
      end
    end
    if (tree[n] != NODE_USED || st != addr) return r;
    r.status = STATUS_OK;
    r.block_start = st[9:0];
    r.block_size = sz[10:0];
    foreach (held_starts[k]) begin
      if (held_starts[k] == addr) begin
        held_starts.delete(k);
        break;
      end
    end
    tree[n] = NODE_FREE;
    while (n > 1 && tree[n ^ 1] == NODE_FREE) begin
      tree[n] = NODE_ABSENT;
      tree[n ^ 1] = NODE_ABSENT;
      n = n / 2;
      tree[n] = NODE_FREE;
    end
    return r;
  endfunction

  task automatic send_request(logic mode, int req_size, int addr);
    bma_in_t item;
    int gap;
    gap = $urandom_range(0, 6);
    // With no gap, start stays high straight into the next request.
    if (gap > 0) begin
      start <= 1'b0;
      in_req <= {1'b0, 11'($urandom), 10'($urandom)};
    end
    repeat (gap) @(posedge clk);
    item.mode = mode;
    item.request_size = req_size[10:0];
    item.free_address = addr[9:0];
    start <= 1'b1;
    in_req <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Taken at this edge; predict now so that ordering matches the block.
    if (mode == 1'b0) begin
      pending_results.push_back(predict_allocate(req_size));
      alloc_count++;
    end else begin
      pending_results.push_back(predict_free(addr));
      free_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      bma_out_t want;
      result_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d", out_res.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_res.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_res.status);
          fail_count++;
        end
        if (out_res.block_start !== want.block_start) begin
          $error("block_start expected %0d actual %0d", want.block_start,
                 out_res.block_start);
          fail_count++;
        end
        if (out_res.block_size !== want.block_size) begin
          $error("block_size expected %0d actual %0d", want.block_size,
                 out_res.block_size);
          fail_count++;
        end
      end
    end
  end

  function automatic int random_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, 40);
    if (pick < 9) return $urandom_range(0, 300);
    return $urandom_range(0, 2047);
  endfunction

  task automatic free_everything();
    while (held_starts.size() > 0) send_request(1'b1, $urandom, held_starts[0]);
  endtask

  task automatic test_directed();
    send_request(1'b0, 0, 1023);
    send_request(1'b1, 2047, 0);
    send_request(1'b0, 1024, 0);
    send_request(1'b0, 1, 0);
    send_request(1'b1, 0, 1);
    send_request(1'b1, 0, 1023);
    send_request(1'b0, 2047, 0);
    send_request(1'b0, 1025, 0);
    send_request(1'b0, 512, 0);
    send_request(1'b0, 513, 0);
    send_request(1'b0, 3, 0);
    send_request(1'b1, 0, 0);
    send_request(1'b1, 0, 0);
    send_request(1'b0, 1, 0);
    send_request(1'b1, 0, 512);
    free_everything();
    send_request(1'b0, 1024, 0);
    send_request(1'b0, 1, 0);
    send_request(1'b1, 1024, 0);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 400; i++) begin
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_request(1'b0, random_size(), $urandom);
      end else if (pick < 9 && held_starts.size() > 0) begin
        send_request(1'b1, $urandom,
                     held_starts[$urandom_range(0, held_starts.size() - 1)]);
      end else begin
        send_request(1'b1, $urandom, $urandom_range(0, 1023));
      end
    end
    free_everything();
  endtask

  task automatic test_fill_and_drain();
    for (int i = 0; i < 60; i++) send_request(1'b0, $urandom_range(1, 64), $urandom);
    while (held_starts.size() > 0) begin
      int k;
      k = $urandom_range(0, held_starts.size() - 1);
      send_request(1'b1, $urandom, held_starts[k]);
    end
  endtask

  initial begin
    int waited;
    reset_tree();
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix();
    test_fill_and_drain();
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    $display("Ran %0d allocates and %0d frees, %0d results checked.",
             alloc_count, free_count, result_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
